// ----- rtl/core/fpcc_pkg.sv -----
// ----------------------------------------------------------------------------
// fpcc_pkg
// Shared types and constants for the fp32 convert/compare unit.
// ----------------------------------------------------------------------------
package fpcc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned FuncW = 3;
  localparam logic [7:0]  ExpMax = 8'hFF;
  localparam logic [7:0]  Bias   = 8'd127;
  localparam logic [31:0] SignBit = 32'h8000_0000;

  typedef enum logic [FuncW-1:0] {
    FUNC_I2F  = 3'd0,
    FUNC_U2F  = 3'd1,
    FUNC_F2I  = 3'd2,
    FUNC_EQ   = 3'd3,
    FUNC_LT   = 3'd4,
    FUNC_RSV5 = 3'd5,
    FUNC_RSV6 = 3'd6,
    FUNC_RSV7 = 3'd7
  } func_e;

endpackage

// ----- rtl/core/fpcc_stream_if.sv -----
// ----------------------------------------------------------------------------
// fpcc_stream_if
// Valid/ready channels: an input with func and two operands, an output with the result.
// ----------------------------------------------------------------------------
interface fpcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [fpcc_pkg::FuncW-1:0]    func;
  logic [fpcc_pkg::DataW-1:0]    operand_a;
  logic [fpcc_pkg::DataW-1:0]    operand_b;
  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpcc_out_if;
  logic                       valid;
  logic                       ready;
  logic [fpcc_pkg::DataW-1:0] result;
  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

// ----- rtl/core/fp32_convert_compare_unit.sv -----
// ----------------------------------------------------------------------------
// fp32_convert_compare_unit
// int/uint to fp32 (RNE), fp32 to int (truncate), fp32 equal and less.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  in_i     | in  | func, operand_a, operand_b
//  out_o    | out | result
//
// Three register stages: S1 magnitude/decode, S2 normalize shift, S3 round/pack.
// One item per cycle sustained while out_o is ready; an accepted item passes
// the S1, S2 and S3 registers in order before out valid rises.
// A stall holds stage 3; an earlier stage moves when the one after it is empty
// or moving. Reset clears the stage valid bits only.
module fp32_convert_compare_unit (
  input  logic clk_i,
  input  logic rst_ni,
  fpcc_in_if.sink    in_i,
  fpcc_out_if.source out_o
);

  // stage valids and advance
  logic v1_q, v2_q, v3_q;
  logic adv1, adv2, adv3;
  assign adv3 = !v3_q || out_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign in_i.ready = adv1;

  // ---------------- stage 1: decode, magnitude, compares, f2i ---------------
  logic [2:0]  func1_d, func1_q;
  logic        sign1_d, sign1_q;
  logic [31:0] mag1_d, mag1_q;     // magnitude, f2i mantissa, or final result for cmp
  logic [4:0]  msb1_d, msb1_q;
  logic [31:0] a, b;
  logic        nan_a, nan_b, zz, lt_raw;
  logic [7:0]  ea;
  logic [23:0] m24;
  logic [7:0]  ue;

  assign a = in_i.operand_a;
  assign b = in_i.operand_b;
  assign ea = a[30:23];
  assign m24 = {1'b1, a[22:0]};
  assign ue = ea - fpcc_pkg::Bias;

  always_comb begin
    nan_a = (a[30:23] == fpcc_pkg::ExpMax) && (a[22:0] != 23'd0);
    nan_b = (b[30:23] == fpcc_pkg::ExpMax) && (b[22:0] != 23'd0);
    zz = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (a[31] != b[31]) lt_raw = a[31];
    else if (!a[31]) lt_raw = a < b;
    else lt_raw = a > b;
    func1_d = in_i.func;
    sign1_d = 1'b0;
    mag1_d = 32'd0;
    msb1_d = 5'd0;
    unique case (fpcc_pkg::func_e'(in_i.func))
      fpcc_pkg::FUNC_I2F: begin
        sign1_d = a[31];
        mag1_d = a[31] ? (32'd0 - a) : a;
      end
      fpcc_pkg::FUNC_U2F: mag1_d = a;
      fpcc_pkg::FUNC_F2I: begin
        // operand range; shift happens in stage 2
        sign1_d = a[31];
        if (ea == fpcc_pkg::ExpMax || (ea >= fpcc_pkg::Bias && ue >= 8'd31)) begin
          mag1_d = fpcc_pkg::SignBit;
          msb1_d = 5'd31;          // marks saturate
        end else if (ea < fpcc_pkg::Bias) begin
          mag1_d = 32'd0;
        end else begin
          mag1_d = {8'd0, m24};
          msb1_d = ue[4:0];
        end
      end
      fpcc_pkg::FUNC_EQ:
        mag1_d = {31'd0, !nan_a && !nan_b && (a == b || zz)};
      fpcc_pkg::FUNC_LT:
        mag1_d = {31'd0, !nan_a && !nan_b && !zz && lt_raw};
      default: mag1_d = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_i.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      func1_q <= func1_d;
      sign1_q <= sign1_d;
      mag1_q <= mag1_d;
      msb1_q <= msb1_d;
    end
  end

  // ---------------- stage 2: leading one and normalize ----------------------
  logic [2:0]  func2_q;
  logic        sign2_q, zero2_d, zero2_q;
  logic [31:0] norm2_d, norm2_q;
  logic [4:0]  lz, msb2_d, msb2_q;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag1_q[i]) lz = 5'(31 - i);
    end
    zero2_d = (mag1_q == 32'd0);
    msb2_d = 5'd31 - lz;
    norm2_d = mag1_q << lz;
    if (fpcc_pkg::func_e'(func1_q) == fpcc_pkg::FUNC_F2I) begin
      msb2_d = msb1_q;
      if (msb1_q == 5'd31 || zero2_d) norm2_d = mag1_q;
      else if (msb1_q >= 5'd23) norm2_d = mag1_q << (msb1_q - 5'd23);
      else norm2_d = mag1_q >> (5'd23 - msb1_q);
    end else if (fpcc_pkg::func_e'(func1_q) != fpcc_pkg::FUNC_I2F &&
                 fpcc_pkg::func_e'(func1_q) != fpcc_pkg::FUNC_U2F) begin
      norm2_d = mag1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv2) begin
      func2_q <= func1_q;
      sign2_q <= sign1_q;
      zero2_q <= zero2_d;
      norm2_q <= norm2_d;
      msb2_q <= msb2_d;
    end
  end

  // ---------------- stage 3: round and pack ---------------------------------
  logic [31:0] res3_d, res3_q;
  logic [24:0] mant_r;
  logic        rnd;
  logic [7:0]  expo;

  always_comb begin
    // norm2_q has leading one at bit 31; keep bit 8 as lsb
    rnd = norm2_q[7] && (norm2_q[6:0] != 7'd0 || norm2_q[8]);
    mant_r = {1'b0, norm2_q[31:8]} + {24'd0, rnd};
    expo = {3'd0, msb2_q} + fpcc_pkg::Bias + {7'd0, mant_r[24]};
    unique case (fpcc_pkg::func_e'(func2_q))
      fpcc_pkg::FUNC_I2F, fpcc_pkg::FUNC_U2F: begin
        if (zero2_q) res3_d = 32'd0;
        else res3_d = {sign2_q, expo,
                       mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
      end
      fpcc_pkg::FUNC_F2I: begin
        if (msb2_q == 5'd31 && norm2_q == fpcc_pkg::SignBit) res3_d = norm2_q;
        else res3_d = sign2_q ? (32'd0 - norm2_q) : norm2_q;
      end
      default: res3_d = norm2_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv3) res3_q <= res3_d;
  end

  assign out_o.valid  = v3_q;
  assign out_o.result = res3_q;

`ifndef SYNTHESIS
  // a stalled output stage holds its result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !out_o.ready |=> v3_q && $stable(res3_q))
    else $error("output changed under stall");
  // input ready follows from downstream space
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> in_i.ready)
    else $error("ready low with empty stage 1");
  // an item in stage 2 moves on when the output drains
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && out_o.ready |=> v3_q)
    else $error("item lost between stages");
`endif

endmodule
